// ===== rtl/fpt_pkg.sv =====
// Shared types, field widths, register indexes and helpers for the face
// position tracker. Has no dependencies; imported by every module of the block.
`default_nettype none

package fpt_pkg;

    // Field widths fixed by the stream format
    localparam int COORD_W   = 11;
    localparam int FRAME_W   = 32;
    localparam int ID_W      = 10;
    localparam int RADIUS_W  = 10;
    localparam int KEEP_W    = 16;
    localparam int REMOVED_W = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Stream word widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_FRAMES  = 1'b1;

    // Register reset values
    localparam logic [RADIUS_W-1:0] TRACK_RADIUS_RST = 10'd40;
    localparam logic [KEEP_W-1:0]   KEEP_FRAMES_RST  = 16'd10;

    // Sweep drop counter saturates here
    localparam logic [REMOVED_W-1:0] REMOVED_MAX = 5'h1F;

    // Action codes carried in tuser
    localparam logic ACT_DETECT = 1'b0;
    localparam logic ACT_SWEEP  = 1'b1;

    // One stored window
    typedef struct packed {
        logic [ID_W-1:0]           track_id;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [FRAME_W-1:0]        last_frame;
    } fpt_entry_t;

    // Input word after center computation
    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [FRAME_W-1:0]        frame_number;
    } fpt_item_t;

    // Result word
    typedef struct packed {
        logic [REMOVED_W-1:0] removed_count;
        logic                 table_full;
        logic                 matched;
        logic [ID_W-1:0]      track_id;
    } fpt_result_t;

    // Compare outcome for one stored entry
    typedef struct packed {
        logic near;
        logic alive;
    } fpt_eval_t;

    // Half the sum of two coordinates, truncated toward zero
    function automatic logic signed [COORD_W-1:0] fpt_center(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] sum;
        sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        // negative sums round up before the floor shift
        sum = sum + {{COORD_W{1'b0}}, sum[COORD_W]};
        return sum[COORD_W:1];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fpt_match.sv =====
// Distance and aging test of one stored window against the current word.
// Depends on fpt_pkg.
`default_nettype none

module fpt_match import fpt_pkg::*; (
    input  fpt_entry_t                 entry,
    input  logic signed [COORD_W-1:0]  cur_x,
    input  logic signed [COORD_W-1:0]  cur_y,
    input  logic [FRAME_W-1:0]         frame_number,
    input  logic [RADIUS_W-1:0]        track_radius,
    input  logic [KEEP_W-1:0]          keep_frames,
    output fpt_eval_t                  eval
);

    logic signed [COORD_W+1:0] dx;
    logic signed [COORD_W+1:0] dy;
    logic signed [COORD_W+1:0] rad;
    logic [FRAME_W:0]          limit;

    // differences fit in COORD_W+1 bits; one more bit for negation
    assign dx  = {{2{entry.pos_x[COORD_W-1]}}, entry.pos_x}
               - {{2{cur_x[COORD_W-1]}}, cur_x};
    assign dy  = {{2{entry.pos_y[COORD_W-1]}}, entry.pos_y}
               - {{2{cur_y[COORD_W-1]}}, cur_y};
    assign rad = {{(COORD_W+2-RADIUS_W){1'b0}}, track_radius};

    assign eval.near = (dx < rad) && (-dx < rad) && (dy < rad) && (-dy < rad);

    // aging sum carries into a spare bit, never wraps
    assign limit      = {1'b0, entry.last_frame}
                      + {{(FRAME_W+1-KEEP_W){1'b0}}, keep_frames};
    assign eval.alive = limit >= {1'b0, frame_number};

endmodule

`default_nettype wire

// ===== rtl/fpt_engine.sv =====
// Window table in a synchronous RAM plus the scan sequencer that matches,
// appends and compacts entries. Depends on fpt_pkg and fpt_match.
`default_nettype none

module fpt_engine import fpt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ID_MODULUS    = 1000
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [RADIUS_W-1:0] track_radius,
    input  logic [KEEP_W-1:0]   keep_frames,
    input  logic                item_valid,
    output logic                item_ready,
    input  fpt_item_t           item,
    output logic                res_valid,
    input  logic                res_ready,
    output fpt_result_t         result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
    localparam logic [ID_W-1:0]  ID_LAST  = ID_W'(ID_MODULUS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    fpt_item_t item_reg, item_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] eval_idx_reg, eval_idx_next;
    logic [CNT_W-1:0] wr_idx_reg, wr_idx_next;
    logic [REMOVED_W-1:0] removed_reg, removed_next;
    logic [ID_W-1:0] next_id_reg, next_id_next;
    fpt_result_t result_reg, result_next;

    // Table RAM, one read and one write port, registered read data
    fpt_entry_t mem [TABLE_ENTRIES];
    fpt_entry_t rd_data_reg;
    logic mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    fpt_entry_t mem_wdata;

    fpt_eval_t ev;
    logic scan_end;

    // Compare the entry just read with the current word
    fpt_match u_match (
        .entry        (rd_data_reg),
        .cur_x        (item_reg.pos_x),
        .cur_y        (item_reg.pos_y),
        .frame_number (item_reg.frame_number),
        .track_radius (track_radius),
        .keep_frames  (keep_frames),
        .eval         (ev)
    );

    // Writes always land at or below the slot under test, reads run ahead,
    // so a read and a write never hit the same entry in one cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign scan_end = !rd_vld_reg && (rd_idx_reg == count_reg);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        rd_vld_next   = rd_vld_reg;
        eval_idx_next = eval_idx_reg;
        wr_idx_next   = wr_idx_reg;
        removed_next  = removed_reg;
        next_id_next  = next_id_reg;
        result_next   = result_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = rd_data_reg;
        mem_re        = 1'b0;
        mem_raddr     = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    item_next    = item;
                    rd_idx_next  = '0;
                    rd_vld_next  = 1'b0;
                    wr_idx_next  = '0;
                    removed_next = '0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue the next read while entries remain
                if (rd_idx_reg != count_reg) begin
                    mem_re        = 1'b1;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    rd_vld_next   = 1'b1;
                    eval_idx_next = rd_idx_reg[IDX_W-1:0];
                end else begin
                    rd_vld_next = 1'b0;
                end

                if (item_reg.action == ACT_SWEEP) begin
                    // keep survivors in order, drop aged entries
                    if (rd_vld_reg) begin
                        if (ev.alive) begin
                            if (wr_idx_reg[IDX_W-1:0] != eval_idx_reg) begin
                                mem_we    = 1'b1;
                                mem_waddr = wr_idx_reg[IDX_W-1:0];
                                mem_wdata = rd_data_reg;
                            end
                            wr_idx_next = wr_idx_reg + 1'b1;
                        end else if (removed_reg != REMOVED_MAX) begin
                            removed_next = removed_reg + 1'b1;
                        end
                    end
                    if (scan_end) begin
                        count_next                = wr_idx_reg;
                        result_next.track_id      = '0;
                        result_next.matched       = 1'b0;
                        result_next.table_full    = 1'b0;
                        result_next.removed_count = removed_reg;
                        state_next                = ST_DONE;
                    end
                end else begin
                    if (rd_vld_reg && ev.near && ev.alive) begin
                        // first match: refresh center and frame
                        mem_we                    = 1'b1;
                        mem_waddr                 = eval_idx_reg;
                        mem_wdata.track_id        = rd_data_reg.track_id;
                        mem_wdata.pos_x           = item_reg.pos_x;
                        mem_wdata.pos_y           = item_reg.pos_y;
                        mem_wdata.last_frame      = item_reg.frame_number;
                        result_next.track_id      = rd_data_reg.track_id;
                        result_next.matched       = 1'b1;
                        result_next.table_full    = 1'b0;
                        result_next.removed_count = '0;
                        state_next                = ST_DONE;
                    end else if (scan_end) begin
                        result_next.matched       = 1'b0;
                        result_next.removed_count = '0;
                        if (count_reg == CNT_FULL) begin
                            result_next.track_id   = '0;
                            result_next.table_full = 1'b1;
                        end else begin
                            // append a new window at the tail
                            mem_we                 = 1'b1;
                            mem_waddr              = count_reg[IDX_W-1:0];
                            mem_wdata.track_id     = next_id_reg;
                            mem_wdata.pos_x        = item_reg.pos_x;
                            mem_wdata.pos_y        = item_reg.pos_y;
                            mem_wdata.last_frame   = item_reg.frame_number;
                            count_next             = count_reg + 1'b1;
                            next_id_next           = (next_id_reg == ID_LAST) ? '0
                                                   : next_id_reg + 1'b1;
                            result_next.track_id   = next_id_reg;
                            result_next.table_full = 1'b0;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            next_id_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    // Payload and scan pointers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        rd_idx_reg   <= rd_idx_next;
        eval_idx_reg <= eval_idx_next;
        wr_idx_reg   <= wr_idx_next;
        removed_reg  <= removed_next;
        result_reg   <= result_next;
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign result     = result_reg;

endmodule

`default_nettype wire

// ===== rtl/face_position_tracker_top.sv =====
// Top level of the face position tracker: stream ports, configuration
// registers, center computation and result register. Depends on fpt_pkg, fpt_engine.
`default_nettype none

// The tracker holds up to TABLE_ENTRIES face windows in one on-chip RAM,
// oldest first, with a fill count in place of per-entry valid bits, so no
// clearing pass follows reset. Each word (detection or sweep) walks the
// stored entries one per cycle through the single RAM read port; the result
// word is then held in the output register, and the next input word can be
// taken once the engine has handed that result over. A detection that
// matches early stops the walk there. One word is worked on at a time; a
// new word is taken while the previous result still waits on the output.
// Configuration writes must only be made while no word is in flight.
module face_position_tracker_top import fpt_pkg::*; #(
    parameter int TABLE_ENTRIES = 16,
    parameter int ID_MODULUS    = 1000
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // box_left[10:0], box_top[21:11], box_right[32:22], box_bottom[43:33],
    // frame_number[75:44], zero fill[79:76]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action[0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // track_id[9:0], matched[10], table_full[11], removed_count[16:12],
    // zero fill[23:17]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [RADIUS_W-1:0] track_radius_reg;
    logic [KEEP_W-1:0]   keep_frames_reg;
    fpt_item_t           item;
    logic                res_valid, res_ready;
    fpt_result_t         result;
    logic                m_tvalid_reg, m_tvalid_next;
    fpt_result_t         m_result_reg, m_result_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_radius_reg <= TRACK_RADIUS_RST;
            keep_frames_reg  <= KEEP_FRAMES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TRACK_RADIUS: track_radius_reg <= cfg_wr_data[RADIUS_W-1:0];
                CFG_KEEP_FRAMES:  keep_frames_reg  <= cfg_wr_data[KEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the input word and form box centers
    always_comb begin
        item.action       = s_tuser[0];
        item.pos_x        = fpt_center(s_tdata[10:0], s_tdata[32:22]);
        item.pos_y        = fpt_center(s_tdata[21:11], s_tdata[43:33]);
        item.frame_number = s_tdata[75:44];
    end

    fpt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ID_MODULUS    (ID_MODULUS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .track_radius (track_radius_reg),
        .keep_frames  (keep_frames_reg),
        .item_valid   (s_tvalid),
        .item_ready   (s_tready),
        .item         (item),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .result       (result)
    );

    // Output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_result_next = m_result_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_result_next = result;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_result_reg <= m_result_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W - REMOVED_W - 2){1'b0}},
                       m_result_reg.removed_count, m_result_reg.table_full,
                       m_result_reg.matched, m_result_reg.track_id};

`ifndef NO_ASSERTIONS
    // a window is never both matched and refused
    a_match_excl_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_result_reg.matched && m_result_reg.table_full))
        else $error("matched and table_full both set");

    // refused detections and sweeps carry id zero
    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_result_reg.table_full || m_result_reg.removed_count != '0))
        |-> (m_result_reg.track_id == '0))
        else $error("nonzero id on full or sweep result");

    // the engine is busy on the cycle after it takes a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken twice in a row");
`endif

endmodule

`default_nettype wire
